// ===== sv/ssc_pkg.sv =====
// Package for the stepper shutter controller: types, codes and constants.
// Used by every module of the block; no dependencies.
package ssc_pkg;

    localparam int DIST_W     = 12;
    localparam int SPM_W      = 10;
    localparam int DEB_W      = 4;
    localparam int PROD_W     = SPM_W + DIST_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    localparam logic [SPM_W-1:0]  SPM_RESET    = 10'd80;
    localparam logic [DIST_W-1:0] TRAVEL_RESET = 12'd500;
    localparam logic [DEB_W-1:0]  DEB_RESET    = 4'd3;
    localparam logic [DEB_W-1:0]  HIT_MAX      = 4'd15;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_HOME  = 2'd1,
        OP_OPEN  = 2'd2,
        OP_CLOSE = 2'd3
    } t_opcode;

    typedef enum logic [2:0] {
        M_INIT    = 3'd0,
        M_HOMING  = 3'd1,
        M_CLOSED  = 3'd2,
        M_OPENING = 3'd3,
        M_OPEN    = 3'd4,
        M_CLOSING = 3'd5,
        M_FAULT   = 3'd6
    } t_mode;

    typedef enum logic [3:0] {
        C_NONE         = 4'd0,
        C_HOME_CMD     = 4'd1,
        C_OPEN_CMD     = 4'd2,
        C_CLOSE_CMD    = 4'd3,
        C_SOFT_LIMIT   = 4'd4,
        C_HOME_OK      = 4'd5,
        C_HOME_TIMEOUT = 4'd6,
        C_HIT_OPEN     = 4'd7,
        C_TARGET       = 4'd8,
        C_HIT_CLOSED   = 4'd9
    } t_cause;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_STEP_SCALE      = 2'd0,
        REG_TRAVEL_LIMIT_MM = 2'd1,
        REG_DEBOUNCE_READS  = 2'd2
    } t_reg_index;

    typedef struct packed {
        logic [SPM_W-1:0]  step_scale;
        logic [DIST_W-1:0] travel_limit_mm;
        logic [DEB_W-1:0]  debounce_reads;
    } t_cfg;

    typedef struct packed {
        t_opcode           opcode;
        logic [DIST_W-1:0] distance_mm;
        logic              open_switch;
        logic              closed_switch;
    } t_item;

    typedef struct packed {
        t_cause cause;
        logic   direction_open;
        logic   motor_enable;
        logic   step_pulse;
        t_mode  mode;
    } t_result;

    // Clamp a millimetre-to-step product to the all-ones value of a count of bits.
    function automatic logic [31:0] sat_steps(input logic [PROD_W-1:0] p, input int bits);
        logic [32:0] cmax;
        cmax = (33'd1 << bits) - 33'd1;
        return (33'(p) > cmax) ? cmax[31:0] : 32'(p);
    endfunction

endpackage

// ===== sv/ssc_cfg.sv =====
// Configuration registers of the shutter controller and the registered soft-limit step count.
// Depends on ssc_pkg.
module ssc_cfg #(
    parameter int STEP_COUNT_BITS = 23
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_wr,
    input  logic [ssc_pkg::CFG_IDX_W-1:0]    i_index,
    input  logic [ssc_pkg::CFG_DATA_W-1:0]   i_data,
    output ssc_pkg::t_cfg                    o_cfg,
    output logic [STEP_COUNT_BITS-1:0]       o_limit_steps
);

    ssc_pkg::t_cfg               r_cfg;
    logic [STEP_COUNT_BITS-1:0]  r_limit_steps;
    logic [ssc_pkg::PROD_W-1:0]  w_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.step_scale      <= ssc_pkg::SPM_RESET;
            r_cfg.travel_limit_mm <= ssc_pkg::TRAVEL_RESET;
            r_cfg.debounce_reads  <= ssc_pkg::DEB_RESET;
        end else if (i_wr) begin
            unique case (i_index)
                ssc_pkg::REG_STEP_SCALE:
                    r_cfg.step_scale <= i_data[ssc_pkg::SPM_W-1:0];
                ssc_pkg::REG_TRAVEL_LIMIT_MM:
                    r_cfg.travel_limit_mm <= i_data[ssc_pkg::DIST_W-1:0];
                ssc_pkg::REG_DEBOUNCE_READS:
                    r_cfg.debounce_reads <= i_data[ssc_pkg::DEB_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign w_prod = ssc_pkg::PROD_W'(r_cfg.travel_limit_mm)
                  * ssc_pkg::PROD_W'(r_cfg.step_scale);

    always_ff @(posedge i_clk) begin
        r_limit_steps <= STEP_COUNT_BITS'(ssc_pkg::sat_steps(w_prod, STEP_COUNT_BITS));
    end

    assign o_cfg         = r_cfg;
    assign o_limit_steps = r_limit_steps;

endmodule

// ===== sv/ssc_in_stage.sv =====
// Input register of the shutter controller: holds one accepted item and its distance in steps.
// Depends on ssc_pkg.
module ssc_in_stage #(
    parameter int STEP_COUNT_BITS = 23
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  ssc_pkg::t_item                   i_item,
    input  logic [ssc_pkg::SPM_W-1:0]        i_step_scale,
    input  logic                             i_advance,
    output logic                             o_valid,
    output ssc_pkg::t_item                   o_item,
    output logic [STEP_COUNT_BITS-1:0]       o_dist_steps
);

    logic                        r_valid;
    ssc_pkg::t_item              r_item;
    logic [STEP_COUNT_BITS-1:0]  r_dist_steps;
    logic [ssc_pkg::PROD_W-1:0]  w_prod;
    logic                        w_take;

    assign o_ready = !r_valid || i_advance;
    assign w_take  = i_valid && o_ready;
    assign w_prod  = ssc_pkg::PROD_W'(i_item.distance_mm) * ssc_pkg::PROD_W'(i_step_scale);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_item       <= i_item;
            r_dist_steps <= STEP_COUNT_BITS'(ssc_pkg::sat_steps(w_prod, STEP_COUNT_BITS));
        end
    end

    assign o_valid      = r_valid;
    assign o_item       = r_item;
    assign o_dist_steps = r_dist_steps;

endmodule

// ===== sv/ssc_core.sv =====
// Mode controller of the shutter: state registers, debounce, step count and result register.
// Depends on ssc_pkg.
module ssc_core #(
    parameter int STEP_COUNT_BITS = 23
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    input  ssc_pkg::t_item                   i_item,
    input  logic [STEP_COUNT_BITS-1:0]       i_dist_steps,
    input  ssc_pkg::t_cfg                    i_cfg,
    input  logic [STEP_COUNT_BITS-1:0]       i_limit_steps,
    output logic                             o_advance,
    output logic                             o_valid,
    input  logic                             i_ready,
    output ssc_pkg::t_result                 o_result
);

    localparam logic [STEP_COUNT_BITS-1:0] COUNT_MAX = '1;

    ssc_pkg::t_mode              r_mode, n_mode;
    logic [STEP_COUNT_BITS-1:0]  r_steps, n_steps;
    logic [STEP_COUNT_BITS-1:0]  r_target, n_target;
    logic [ssc_pkg::DEB_W-1:0]   r_open_hits, n_open_hits;
    logic [ssc_pkg::DEB_W-1:0]   r_closed_hits, n_closed_hits;
    logic                        r_enable, n_enable;
    logic                        r_dir, n_dir;
    logic                        r_out_valid;
    ssc_pkg::t_result            r_result, n_result;

    logic [STEP_COUNT_BITS-1:0]  w_steps_inc;
    logic [ssc_pkg::DEB_W-1:0]   w_open_f, w_closed_f;
    logic                        w_open_hit, w_closed_hit;
    logic                        w_over;
    logic                        w_fire;
    ssc_pkg::t_cause             w_cause;
    logic                        w_pulse;

    assign o_advance = !r_out_valid || i_ready;
    assign w_fire    = i_valid && o_advance;

    assign w_steps_inc = (r_steps == COUNT_MAX) ? r_steps : r_steps + 1'b1;

    assign w_open_f  = !i_item.open_switch ? '0 :
                       (r_open_hits < ssc_pkg::HIT_MAX) ? r_open_hits + 1'b1 : r_open_hits;
    assign w_closed_f = !i_item.closed_switch ? '0 :
                       (r_closed_hits < ssc_pkg::HIT_MAX) ? r_closed_hits + 1'b1 : r_closed_hits;
    assign w_open_hit   = i_item.open_switch && (w_open_f >= i_cfg.debounce_reads);
    assign w_closed_hit = i_item.closed_switch && (w_closed_f >= i_cfg.debounce_reads);

    assign w_over = i_item.distance_mm > i_cfg.travel_limit_mm;

    always_comb begin
        n_mode        = r_mode;
        n_steps       = r_steps;
        n_target      = r_target;
        n_open_hits   = r_open_hits;
        n_closed_hits = r_closed_hits;
        n_enable      = r_enable;
        n_dir         = r_dir;
        w_cause       = ssc_pkg::C_NONE;
        w_pulse       = 1'b0;
        unique case (i_item.opcode)
            ssc_pkg::OP_HOME: begin
                n_steps       = '0;
                n_target      = i_limit_steps;
                n_closed_hits = '0;
                n_enable      = 1'b1;
                n_dir         = 1'b0;
                n_mode        = ssc_pkg::M_HOMING;
                w_cause       = ssc_pkg::C_HOME_CMD;
            end
            ssc_pkg::OP_OPEN, ssc_pkg::OP_CLOSE: begin
                if (w_over) begin
                    n_mode  = ssc_pkg::M_FAULT;
                    w_cause = ssc_pkg::C_SOFT_LIMIT;
                end else begin
                    n_steps  = '0;
                    n_target = i_dist_steps;
                    n_enable = 1'b1;
                    if (i_item.opcode == ssc_pkg::OP_OPEN) begin
                        n_open_hits = '0;
                        n_dir       = 1'b1;
                        n_mode      = ssc_pkg::M_OPENING;
                        w_cause     = ssc_pkg::C_OPEN_CMD;
                    end else begin
                        n_closed_hits = '0;
                        n_dir         = 1'b0;
                        n_mode        = ssc_pkg::M_CLOSING;
                        w_cause       = ssc_pkg::C_CLOSE_CMD;
                    end
                end
            end
            ssc_pkg::OP_TICK: begin
                unique case (r_mode)
                    ssc_pkg::M_HOMING: begin
                        w_pulse       = 1'b1;
                        n_steps       = w_steps_inc;
                        n_closed_hits = w_closed_f;
                        if (w_closed_hit) begin
                            n_enable = 1'b0;
                            n_mode   = ssc_pkg::M_CLOSED;
                            w_cause  = ssc_pkg::C_HOME_OK;
                        end else if (w_steps_inc >= r_target) begin
                            n_enable = 1'b0;
                            n_mode   = ssc_pkg::M_FAULT;
                            w_cause  = ssc_pkg::C_HOME_TIMEOUT;
                        end
                    end
                    ssc_pkg::M_OPENING: begin
                        w_pulse     = 1'b1;
                        n_steps     = w_steps_inc;
                        n_open_hits = w_open_f;
                        if (w_open_hit) begin
                            n_enable = 1'b0;
                            n_mode   = ssc_pkg::M_OPEN;
                            w_cause  = ssc_pkg::C_HIT_OPEN;
                        end else if (w_steps_inc >= r_target) begin
                            n_enable = 1'b0;
                            n_mode   = ssc_pkg::M_OPEN;
                            w_cause  = ssc_pkg::C_TARGET;
                        end else if (w_steps_inc >= i_limit_steps) begin
                            n_enable = 1'b0;
                            n_mode   = ssc_pkg::M_FAULT;
                            w_cause  = ssc_pkg::C_SOFT_LIMIT;
                        end
                    end
                    ssc_pkg::M_CLOSING: begin
                        w_pulse       = 1'b1;
                        n_steps       = w_steps_inc;
                        n_closed_hits = w_closed_f;
                        if (w_closed_hit) begin
                            n_enable = 1'b0;
                            n_mode   = ssc_pkg::M_CLOSED;
                            w_cause  = ssc_pkg::C_HIT_CLOSED;
                        end else if (w_steps_inc >= r_target) begin
                            n_enable = 1'b0;
                            n_mode   = ssc_pkg::M_CLOSED;
                            w_cause  = ssc_pkg::C_TARGET;
                        end else if (w_steps_inc >= i_limit_steps) begin
                            n_enable = 1'b0;
                            n_mode   = ssc_pkg::M_FAULT;
                            w_cause  = ssc_pkg::C_SOFT_LIMIT;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
            end
        endcase

        n_result.mode           = n_mode;
        n_result.step_pulse     = w_pulse;
        n_result.motor_enable   = n_enable;
        n_result.direction_open = n_dir;
        n_result.cause          = (n_mode == r_mode) ? ssc_pkg::C_NONE : w_cause;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= ssc_pkg::M_INIT;
            r_steps       <= '0;
            r_target      <= '0;
            r_open_hits   <= '0;
            r_closed_hits <= '0;
            r_enable      <= 1'b0;
            r_dir         <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (o_advance) begin
                r_out_valid <= i_valid;
            end
            if (w_fire) begin
                r_mode        <= n_mode;
                r_steps       <= n_steps;
                r_target      <= n_target;
                r_open_hits   <= n_open_hits;
                r_closed_hits <= n_closed_hits;
                r_enable      <= n_enable;
                r_dir         <= n_dir;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_result <= n_result;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_result;

endmodule

// ===== sv/stepper_shutter_controller.sv =====
// Stepper shutter controller, top level.
// Instantiates ssc_cfg, ssc_in_stage and ssc_core; depends on ssc_pkg.
//
// Usage:
//   Commands and ticks arrive on the s_axis channel (tuser = opcode, tdata = distance and
//   the two raw limit-switch levels). Every item yields exactly one result on m_axis:
//   mode after the item, step pulse, motor enable, direction and the cause of a mode change.
//   Registers are written through the cfg channel (index, data), which is always ready;
//   write them only while no item is in flight.
// Pipeline and throughput:
//   An item that transfers waits in the input register, where the distance is scaled to
//   steps; the mode logic's outcome is then loaded into the result register, which drives
//   m_axis. One item per cycle is sustained while m_axis_tready stays high. The soft-limit
//   step count is registered from the travel and scale registers after either is written.
// Reset:
//   Registers return to 80 steps/mm, 500 mm travel, 3 debounce reads; mode goes to init,
//   counts clear, motor disabled, direction toward closed, both stages empty.
// Stall:
//   While m_axis_tready is low the result holds, and the input register still takes one
//   more item; s_axis_tready drops once both stages are full.
module stepper_shutter_controller #(
    parameter int STEP_COUNT_BITS = 23
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // distance_mm[11:0], open_switch, closed_switch
    input  logic [15:0]                     s_axis_tdata,
    input  logic [1:0]                      s_axis_tuser,  // opcode
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [15:0]                     m_axis_tdata,  // mode[2:0], step_pulse, motor_enable,
                                                           // direction_open, cause[3:0]
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [ssc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [ssc_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    ssc_pkg::t_cfg               w_cfg;
    logic [STEP_COUNT_BITS-1:0]  w_limit_steps;
    ssc_pkg::t_item              w_in_item;
    ssc_pkg::t_item              w_item;
    logic                        w_item_valid;
    logic [STEP_COUNT_BITS-1:0]  w_dist_steps;
    logic                        w_advance;
    ssc_pkg::t_result            w_result;

    assign o_cfg_ready = 1'b1;

    assign w_in_item.opcode        = ssc_pkg::t_opcode'(s_axis_tuser);
    assign w_in_item.distance_mm   = s_axis_tdata[11:0];
    assign w_in_item.open_switch   = s_axis_tdata[12];
    assign w_in_item.closed_switch = s_axis_tdata[13];

    ssc_cfg #(
        .STEP_COUNT_BITS (STEP_COUNT_BITS)
    ) u_cfg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_wr          (i_cfg_valid && o_cfg_ready),
        .i_index       (i_cfg_index),
        .i_data        (i_cfg_data),
        .o_cfg         (w_cfg),
        .o_limit_steps (w_limit_steps)
    );

    ssc_in_stage #(
        .STEP_COUNT_BITS (STEP_COUNT_BITS)
    ) u_in_stage (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (s_axis_tvalid),
        .o_ready        (s_axis_tready),
        .i_item         (w_in_item),
        .i_step_scale   (w_cfg.step_scale),
        .i_advance      (w_advance),
        .o_valid        (w_item_valid),
        .o_item         (w_item),
        .o_dist_steps   (w_dist_steps)
    );

    ssc_core #(
        .STEP_COUNT_BITS (STEP_COUNT_BITS)
    ) u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (w_item_valid),
        .i_item        (w_item),
        .i_dist_steps  (w_dist_steps),
        .i_cfg         (w_cfg),
        .i_limit_steps (w_limit_steps),
        .o_advance     (w_advance),
        .o_valid       (m_axis_tvalid),
        .i_ready       (m_axis_tready),
        .o_result      (w_result)
    );

    assign m_axis_tdata = {6'd0, w_result.cause, w_result.direction_open,
                           w_result.motor_enable, w_result.step_pulse, w_result.mode};

    a_rest_disabled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (w_result.mode == ssc_pkg::M_CLOSED || w_result.mode == ssc_pkg::M_OPEN)
        |-> !w_result.motor_enable)
        else $error("motor enabled in a rest mode");

    a_home_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && w_result.cause == ssc_pkg::C_HOME_CMD
        |-> w_result.mode == ssc_pkg::M_HOMING && w_result.motor_enable
            && !w_result.direction_open && !w_result.step_pulse)
        else $error("home command result inconsistent");

    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready && w_item_valid)
        else $error("input stalled while pipeline can move");

endmodule

// ===== tb/stepper_shutter_controller_test.sv =====
`timescale 1ns / 1ps
// Self-checking bench for stepper_shutter_controller: commands and switch ticks go in on s_axis
// and each status word on m_axis is compared with an in-bench model of the shutter state machine.
// Depends on ssc_pkg and the stepper_shutter_controller RTL only.
module stepper_shutter_controller_test;

    localparam int CNT_W = 23;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;
    localparam logic [ssc_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_AT = 330;
    localparam int HOLD_CYCLES = 120;
    localparam int QUIET_LO = 400;
    localparam int QUIET_HI = 560;
    localparam int PHASE_ITEMS = 115;
    localparam int SHOWN_MISSES = 10;

    logic                           i_clk;
    logic                           i_rst_n = 1'b0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    logic [15:0]                    s_axis_tdata = '0;
    logic [1:0]                     s_axis_tuser = '0;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    logic [15:0]                    m_axis_tdata;
    logic                           i_cfg_valid = 1'b0;
    logic                           o_cfg_ready;
    logic [ssc_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [ssc_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;

    stepper_shutter_controller #(
        .STEP_COUNT_BITS(CNT_W)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    ssc_pkg::t_item   command_q[$];
    ssc_pkg::t_result status_q[$];
    ssc_pkg::t_item   cur_cmd;
    int      items_taken = 0;
    int      miss_count = 0;
    int      cycle_count = 0;
    int      hold_left = 0;
    bit      hold_done = 1'b0;

    logic [ssc_pkg::SPM_W-1:0]  spm_now;
    logic [ssc_pkg::DIST_W-1:0] travel_now;
    logic [ssc_pkg::DEB_W-1:0]  deb_now;
    ssc_pkg::t_mode             mode_now;
    logic [CNT_W-1:0]           steps_now;
    logic [CNT_W-1:0]           target_now;
    logic [ssc_pkg::DEB_W-1:0]  open_hits;
    logic [ssc_pkg::DEB_W-1:0]  closed_hits;
    logic                       enable_now;
    logic                       dir_now;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [CNT_W-1:0] mm_to_steps(logic [ssc_pkg::DIST_W-1:0] mm);
        logic [63:0] p;
        p = 64'(mm) * 64'(spm_now);
        return (p > 64'(CNT_MAX)) ? CNT_MAX : CNT_W'(p);
    endfunction

    function automatic bit switch_hit(input logic lvl, inout logic [ssc_pkg::DEB_W-1:0] hits);
        if (!lvl) begin
            hits = '0;
            return 1'b0;
        end
        if (hits != ssc_pkg::HIT_MAX) hits = hits + 1'b1;
        return hits >= deb_now;
    endfunction

    function automatic ssc_pkg::t_result shutter_next(ssc_pkg::t_item it);
        ssc_pkg::t_mode   prior;
        ssc_pkg::t_mode   rest;
        ssc_pkg::t_result r;
        bit               hit;
        bit               opening;
        prior = mode_now;
        r.mode = mode_now;
        r.cause = ssc_pkg::C_NONE;
        r.step_pulse = 1'b0;
        case (it.opcode)
            ssc_pkg::OP_HOME: begin
                steps_now = '0;
                target_now = mm_to_steps(travel_now);
                closed_hits = '0;
                enable_now = 1'b1;
                dir_now = 1'b0;
                r.mode = ssc_pkg::M_HOMING;
                r.cause = ssc_pkg::C_HOME_CMD;
            end
            ssc_pkg::OP_OPEN, ssc_pkg::OP_CLOSE: begin
                if (it.distance_mm > travel_now) begin
                    r.mode = ssc_pkg::M_FAULT;
                    r.cause = ssc_pkg::C_SOFT_LIMIT;
                end else begin
                    steps_now = '0;
                    target_now = mm_to_steps(it.distance_mm);
                    enable_now = 1'b1;
                    if (it.opcode == ssc_pkg::OP_OPEN) begin
                        open_hits = '0;
                        dir_now = 1'b1;
                        r.mode = ssc_pkg::M_OPENING;
                        r.cause = ssc_pkg::C_OPEN_CMD;
                    end else begin
                        closed_hits = '0;
                        dir_now = 1'b0;
                        r.mode = ssc_pkg::M_CLOSING;
                        r.cause = ssc_pkg::C_CLOSE_CMD;
                    end
                end
            end
            default: begin
                if (mode_now == ssc_pkg::M_HOMING || mode_now == ssc_pkg::M_OPENING
                        || mode_now == ssc_pkg::M_CLOSING) begin
                    r.step_pulse = 1'b1;
                    if (steps_now != CNT_MAX) steps_now = steps_now + 1'b1;
                    if (mode_now == ssc_pkg::M_HOMING) begin
                        if (switch_hit(it.closed_switch, closed_hits)) begin
                            enable_now = 1'b0;
                            r.mode = ssc_pkg::M_CLOSED;
                            r.cause = ssc_pkg::C_HOME_OK;
                        end else if (steps_now >= target_now) begin
                            enable_now = 1'b0;
                            r.mode = ssc_pkg::M_FAULT;
                            r.cause = ssc_pkg::C_HOME_TIMEOUT;
                        end
                    end else begin
                        opening = (mode_now == ssc_pkg::M_OPENING);
                        rest = opening ? ssc_pkg::M_OPEN : ssc_pkg::M_CLOSED;
                        if (opening) hit = switch_hit(it.open_switch, open_hits);
                        else hit = switch_hit(it.closed_switch, closed_hits);
                        if (hit) begin
                            enable_now = 1'b0;
                            r.mode = rest;
                            r.cause = opening ? ssc_pkg::C_HIT_OPEN : ssc_pkg::C_HIT_CLOSED;
                        end else if (steps_now >= target_now) begin
                            enable_now = 1'b0;
                            r.mode = rest;
                            r.cause = ssc_pkg::C_TARGET;
                        end else if (steps_now >= mm_to_steps(travel_now)) begin
                            enable_now = 1'b0;
                            r.mode = ssc_pkg::M_FAULT;
                            r.cause = ssc_pkg::C_SOFT_LIMIT;
                        end
                    end
                end
            end
        endcase
        mode_now = r.mode;
        if (r.mode == prior) r.cause = ssc_pkg::C_NONE;
        r.motor_enable = enable_now;
        r.direction_open = dir_now;
        return r;
    endfunction

    function automatic bit gap_roll();
        return ($urandom_range(0, 99) < 8) && !(items_taken >= QUIET_LO && items_taken < QUIET_HI);
    endfunction

    function automatic void note_miss(string what, int want, int got);
        if (miss_count < SHOWN_MISSES)
            $display("mismatch at %0t: %s expected %0d actual %0d", $realtime, what, want, got);
        miss_count++;
    endfunction

    // Sender: advance to the next command once the current one transfers.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                status_q.push_back(shutter_next(cur_cmd));
                items_taken <= items_taken + 1;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (command_q.size() != 0 && !gap_roll()) begin
                    cur_cmd = command_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= {2'b00, cur_cmd.closed_switch, cur_cmd.open_switch,
                                     cur_cmd.distance_mm};
                    s_axis_tuser <= cur_cmd.opcode;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Hold off the receiver once, mid-run, so the block backs up.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_done && items_taken >= HOLD_AT) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        ssc_pkg::t_result got;
        ssc_pkg::t_result want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = ssc_pkg::t_result'(m_axis_tdata[9:0]);
                if (status_q.size() == 0) begin
                    note_miss("unexpected status word", 0, int'(m_axis_tdata));
                end else begin
                    want = status_q.pop_front();
                    if (got.mode !== want.mode)
                        note_miss("mode", int'(want.mode), int'(got.mode));
                    if (got.step_pulse !== want.step_pulse)
                        note_miss("step_pulse", int'(want.step_pulse), int'(got.step_pulse));
                    if (got.motor_enable !== want.motor_enable)
                        note_miss("motor_enable", int'(want.motor_enable),
                                  int'(got.motor_enable));
                    if (got.direction_open !== want.direction_open)
                        note_miss("direction_open", int'(want.direction_open),
                                  int'(got.direction_open));
                    if (got.cause !== want.cause)
                        note_miss("cause", int'(want.cause), int'(got.cause));
                    if (m_axis_tdata[15:10] !== '0)
                        note_miss("pad bits", 0, int'(m_axis_tdata[15:10]));
                end
            end
            m_axis_tready <= (hold_left == 0) && !gap_roll();
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("** stepper_shutter_controller: FAILED **");
            $finish;
        end
    end

    task automatic queue_cmd(ssc_pkg::t_opcode op, logic [ssc_pkg::DIST_W-1:0] span_mm,
                             logic os, logic cs);
        ssc_pkg::t_item it;
        it.opcode = op;
        it.distance_mm = span_mm;
        it.open_switch = os;
        it.closed_switch = cs;
        command_q.push_back(it);
    endtask

    task automatic settle();
        while (command_q.size() != 0 || s_axis_tvalid || status_q.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [ssc_pkg::CFG_IDX_W-1:0] idx,
                             logic [ssc_pkg::CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        case (idx)
            ssc_pkg::REG_STEP_SCALE:      spm_now = data[ssc_pkg::SPM_W-1:0];
            ssc_pkg::REG_TRAVEL_LIMIT_MM: travel_now = data[ssc_pkg::DIST_W-1:0];
            ssc_pkg::REG_DEBOUNCE_READS:  deb_now = data[ssc_pkg::DEB_W-1:0];
            default: ;
        endcase
        repeat (2) @(posedge i_clk);
    endtask

    initial begin
        int                         ph;
        int                         cnt;
        int                         n;
        int                         hit_at;
        int                         pick;
        int                         spm_set;
        int                         travel_set;
        int                         deb_set;
        ssc_pkg::t_opcode           op;
        logic [ssc_pkg::DIST_W-1:0] span_mm;
        logic                       prim;
        logic                       other;

        spm_now = ssc_pkg::SPM_RESET;
        travel_now = ssc_pkg::TRAVEL_RESET;
        deb_now = ssc_pkg::DEB_RESET;
        mode_now = ssc_pkg::M_INIT;
        steps_now = '0;
        target_now = '0;
        open_hits = '0;
        closed_hits = '0;
        enable_now = 1'b0;
        dir_now = 1'b0;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        queue_cmd(ssc_pkg::OP_TICK, 12'd0, 1'b1, 1'b1);
        queue_cmd(ssc_pkg::OP_OPEN, 12'd4095, 1'b0, 1'b0);
        queue_cmd(ssc_pkg::OP_OPEN, 12'd4095, 1'b0, 1'b0);
        queue_cmd(ssc_pkg::OP_TICK, 12'd0, 1'b1, 1'b1);
        queue_cmd(ssc_pkg::OP_HOME, 12'd0, 1'b0, 1'b0);
        queue_cmd(ssc_pkg::OP_OPEN, 12'd0, 1'b0, 1'b0);
        queue_cmd(ssc_pkg::OP_OPEN, 12'd0, 1'b0, 1'b0);
        queue_cmd(ssc_pkg::OP_TICK, 12'd0, 1'b0, 1'b1);
        queue_cmd(ssc_pkg::OP_CLOSE, 12'd500, 1'b0, 1'b0);
        queue_cmd(ssc_pkg::OP_CLOSE, 12'd501, 1'b0, 1'b0);
        queue_cmd(ssc_pkg::OP_HOME, 12'd0, 1'b0, 1'b0);
        repeat (3) queue_cmd(ssc_pkg::OP_TICK, 12'd0, 1'b0, 1'b1);
        queue_cmd(ssc_pkg::OP_TICK, 12'd0, 1'b1, 1'b1);
        settle();

        write_reg(ssc_pkg::REG_STEP_SCALE, 12'hC01);
        write_reg(ssc_pkg::REG_TRAVEL_LIMIT_MM, 12'd3);
        write_reg(ssc_pkg::REG_DEBOUNCE_READS, 12'h0F1);
        write_reg(REG_SPARE, 12'hFFF);
        queue_cmd(ssc_pkg::OP_HOME, 12'd0, 1'b0, 1'b0);
        repeat (3) queue_cmd(ssc_pkg::OP_TICK, 12'd0, 1'b0, 1'b0);
        queue_cmd(ssc_pkg::OP_OPEN, 12'd3, 1'b0, 1'b0);
        queue_cmd(ssc_pkg::OP_TICK, 12'd0, 1'b1, 1'b0);
        queue_cmd(ssc_pkg::OP_CLOSE, 12'd3, 1'b0, 1'b0);
        queue_cmd(ssc_pkg::OP_TICK, 12'd0, 1'b0, 1'b1);
        queue_cmd(ssc_pkg::OP_OPEN, 12'd3, 1'b0, 1'b0);
        queue_cmd(ssc_pkg::OP_TICK, 12'd0, 1'b0, 1'b0);
        settle();
        // shrink travel under a running open so the soft limit trips first
        write_reg(ssc_pkg::REG_TRAVEL_LIMIT_MM, 12'd1);
        queue_cmd(ssc_pkg::OP_TICK, 12'd0, 1'b0, 1'b0);
        settle();

        for (ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin spm_set = 1;    travel_set = 10;   deb_set = 2;  end
                1: begin spm_set = 1023; travel_set = 4095; deb_set = 15; end
                2: begin spm_set = 0;    travel_set = 7;    deb_set = 0;  end
                3: begin spm_set = 2;    travel_set = 0;    deb_set = 1;  end
                4: begin spm_set = 3;    travel_set = 6;    deb_set = 4;  end
                default: begin spm_set = 1; travel_set = 3; deb_set = 3; end
            endcase
            write_reg(ssc_pkg::REG_STEP_SCALE, {2'($urandom_range(0, 3)), 10'(spm_set)});
            write_reg(ssc_pkg::REG_TRAVEL_LIMIT_MM, 12'(travel_set));
            write_reg(ssc_pkg::REG_DEBOUNCE_READS, {8'($urandom_range(0, 255)), 4'(deb_set)});
            if (ph == 5) write_reg(REG_SPARE, 12'($urandom_range(0, 4095)));
            cnt = 0;
            while (cnt < PHASE_ITEMS) begin
                pick = $urandom_range(0, 99);
                if (pick < 15) op = ssc_pkg::OP_TICK;
                else if (pick < 40) op = ssc_pkg::OP_HOME;
                else if (pick < 70) op = ssc_pkg::OP_OPEN;
                else op = ssc_pkg::OP_CLOSE;
                pick = $urandom_range(0, 99);
                if (pick < 60)
                    span_mm = 12'($urandom_range(0, travel_set < 12 ? travel_set : 12));
                else if (pick < 72) span_mm = 12'(travel_set);
                else if (pick < 82)
                    span_mm = 12'(travel_set < 4095 ? travel_set + 1 : travel_set);
                else span_mm = 12'($urandom_range(0, 4095));
                queue_cmd(op, span_mm, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                cnt++;
                n = $urandom_range(1, 30);
                hit_at = $urandom_range(0, 20);
                for (int i = 0; i < n; i++) begin
                    prim = (i >= hit_at) ^ ($urandom_range(0, 9) == 0);
                    other = ($urandom_range(0, 4) == 0);
                    span_mm = 12'($urandom_range(0, 4095));
                    if (op == ssc_pkg::OP_OPEN) queue_cmd(ssc_pkg::OP_TICK, span_mm, prim, other);
                    else queue_cmd(ssc_pkg::OP_TICK, span_mm, other, prim);
                    cnt++;
                end
            end
            settle();
        end

        repeat (8) @(posedge i_clk);
        if (miss_count == 0 && status_q.size() == 0) begin
            $display("** stepper_shutter_controller: PASSED **");
        end else begin
            $display("** stepper_shutter_controller: FAILED **");
        end
        $finish;
    end

endmodule
